@@ rtl/efmp_pkg.sv @@
package efmp_pkg;

  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [7:0]         BLANK_HEADER = 8'hFF;
  localparam logic [4:0]         EXT_MASK     = 5'h1F;
  localparam logic [4:0]         EXT_CODE     = 5'h0F;
  localparam logic [LIMIT_W-1:0] COUNT_MAX    = 11'd2047;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 11'd512;

  localparam logic CMD_CONSUME = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic CAUSE_BLANK = 1'b0;
  localparam logic CAUSE_LIMIT = 1'b1;

  localparam logic REG_PHYSICAL_LIMIT = 1'b0;
  localparam logic REG_MAP_LIMIT      = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_EXT    = 3'd1,
    PH_LOW    = 3'd2,
    PH_HIGH   = 3'd3
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] efuse_byte;
  } in_item_t;

  typedef struct packed {
    logic             write_valid;
    logic [POS_W-1:0] position;
    logic [7:0]       low_byte;
    logic [7:0]       high_byte;
    logic             finished;
    logic             end_cause;
  } out_item_t;

endpackage

@@ rtl/efmp_ifs.sv @@
interface efmp_byte_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] efuse_byte;

  modport source (output valid, output command, output efuse_byte, input ready);
  modport sink (input valid, input command, input efuse_byte, output ready);
endinterface

interface efmp_result_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [9:0] position;
  logic [7:0] low_byte;
  logic [7:0] high_byte;
  logic       finished;
  logic       end_cause;

  modport source (
    output valid, output write_valid, output position, output low_byte,
    output high_byte, output finished, output end_cause, input ready
  );
  modport sink (
    input valid, input write_valid, input position, input low_byte,
    input high_byte, input finished, input end_cause, output ready
  );
endinterface

@@ rtl/efmp_cfg_regs.sv @@
module efmp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [efmp_pkg::ADDR_W-1:0]  paddr,
  input  logic [efmp_pkg::DATA_W-1:0]  pwdata,
  output logic [efmp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [efmp_pkg::LIMIT_W-1:0] physical_limit,
  output logic [efmp_pkg::LIMIT_W-1:0] map_limit
);
  import efmp_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      physical_limit <= LIMIT_RESET;
      map_limit      <= LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_PHYSICAL_LIMIT: physical_limit <= pwdata[LIMIT_W-1:0];
        REG_MAP_LIMIT:      map_limit      <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_PHYSICAL_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, physical_limit};
      REG_MAP_LIMIT:      prdata = {{(DATA_W-LIMIT_W){1'b0}}, map_limit};
      default:            prdata = '0;
    endcase
  end

endmodule

@@ rtl/efmp_parse_core.sv @@
module efmp_parse_core #(
  parameter int unsigned MAX_PHYSICAL_BYTES = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step_en,
  input  efmp_pkg::in_item_t           item,
  input  logic [efmp_pkg::LIMIT_W-1:0] physical_limit,
  input  logic [efmp_pkg::LIMIT_W-1:0] map_limit,
  output logic                         has_result,
  output efmp_pkg::out_item_t          result
);
  import efmp_pkg::*;

  localparam logic [LIMIT_W-1:0] MAX_LIMIT = LIMIT_W'(MAX_PHYSICAL_BYTES);

  phase_t             phase, phase_next;
  logic [LIMIT_W-1:0] consumed, consumed_next;
  logic [7:0]         saved_header, saved_header_next;
  logic [6:0]         record_offset, record_offset_next;
  logic [3:0]         word_enables, word_enables_next;
  logic [1:0]         word_slot, word_slot_next;
  logic [7:0]         pending_low, pending_low_next;
  logic               done, done_next;

  logic [LIMIT_W-1:0] eff_limit;
  logic [LIMIT_W-1:0] consumed_inc;
  logic               limit_after;
  logic [7:0]         b;
  logic [3:0]         adv_en;
  logic [2:0]         adv_from;
  logic [2:0]         adv_slot;
  logic               adv_req;
  logic [POS_W-1:0]   pos;

  function automatic logic [2:0] next_slot(input logic [3:0] en, input logic [2:0] from);
    logic [2:0] s;
    logic       found;
    s     = 3'd4;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!found && (3'(i) >= from) && !en[i]) begin
        s     = 3'(i);
        found = 1'b1;
      end
    end
    return s;
  endfunction

  assign b            = item.efuse_byte;
  assign eff_limit    = (physical_limit > MAX_LIMIT) ? MAX_LIMIT : physical_limit;
  assign consumed_inc = (consumed < COUNT_MAX) ? consumed + 1'b1 : consumed;
  assign limit_after  = consumed_inc >= eff_limit;
  assign pos          = {record_offset, word_slot, 1'b0};

  always_comb begin
    phase_next         = phase;
    consumed_next      = consumed;
    saved_header_next  = saved_header;
    record_offset_next = record_offset;
    word_enables_next  = word_enables;
    word_slot_next     = word_slot;
    pending_low_next   = pending_low;
    done_next          = done;
    adv_req            = 1'b0;
    adv_en             = word_enables;
    adv_from           = 3'd0;
    adv_slot           = 3'd4;
    result             = '0;

    if (item.command == CMD_RESTART) begin
      phase_next         = PH_HEADER;
      consumed_next      = '0;
      saved_header_next  = '0;
      record_offset_next = '0;
      word_enables_next  = 4'hF;
      word_slot_next     = '0;
      pending_low_next   = '0;
      done_next          = 1'b0;
    end else if (!done) begin
      case (phase)
        PH_EXT: begin
          consumed_next      = consumed_inc;
          record_offset_next = {b[7:4], saved_header[7:5]};
          word_enables_next  = b[3:0];
          adv_req            = 1'b1;
          adv_en             = b[3:0];
        end
        PH_LOW: begin
          consumed_next    = consumed_inc;
          pending_low_next = b;
          phase_next       = PH_HIGH;
        end
        PH_HIGH: begin
          consumed_next = consumed_inc;
          if (({1'b0, pos} + 1'b1) < map_limit) begin
            result.write_valid = 1'b1;
            result.position    = pos;
            result.low_byte    = pending_low;
            result.high_byte   = b;
          end
          adv_req  = 1'b1;
          adv_from = {1'b0, word_slot} + 3'd1;
        end
        default: begin
          phase_next = PH_HEADER;
          if (consumed >= eff_limit) begin
            done_next        = 1'b1;
            result.finished  = 1'b1;
            result.end_cause = CAUSE_LIMIT;
          end else begin
            consumed_next = consumed_inc;
            if (b == BLANK_HEADER) begin
              done_next        = 1'b1;
              result.finished  = 1'b1;
              result.end_cause = CAUSE_BLANK;
            end else if ((b[4:0] & EXT_MASK) == EXT_CODE) begin
              saved_header_next = b;
              phase_next        = PH_EXT;
            end else begin
              record_offset_next = {3'b000, b[7:4]};
              word_enables_next  = b[3:0];
              adv_req            = 1'b1;
              adv_en             = b[3:0];
            end
          end
        end
      endcase

      adv_slot = next_slot(adv_en, adv_from);

      if (adv_req) begin
        if (!adv_slot[2]) begin
          word_slot_next = adv_slot[1:0];
          phase_next     = PH_LOW;
        end else begin
          word_slot_next = '0;
          phase_next     = PH_HEADER;
          if (limit_after) begin
            done_next        = 1'b1;
            result.finished  = 1'b1;
            result.end_cause = CAUSE_LIMIT;
          end
        end
      end
    end

    has_result = result.write_valid || result.finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      consumed      <= '0;
      saved_header  <= '0;
      record_offset <= '0;
      word_enables  <= 4'hF;
      word_slot     <= '0;
      pending_low   <= '0;
      done          <= 1'b0;
    end else if (step_en) begin
      phase         <= phase_next;
      consumed      <= consumed_next;
      saved_header  <= saved_header_next;
      record_offset <= record_offset_next;
      word_enables  <= word_enables_next;
      word_slot     <= word_slot_next;
      pending_low   <= pending_low_next;
      done          <= done_next;
    end
  end

endmodule

@@ rtl/efuse_tuple_map_parser_unit.sv @@
// Efuse tuple map parser.
// byte_in carries one beat per physical efuse byte in address order; command
// restarts the parse from the first byte. result_out carries one beat for each
// logical map word write and for the end of the parse (blank header or
// physical limit); a write that closes the last record carries both in one
// beat. Bytes that only advance the parser produce no beat.
// Each accepted byte is held in the input register and its result in the
// result register, which drives result_out. Throughput: one byte per cycle
// while result_out does not stall; the input register and the result
// register are the only stages, and the parser state updates once per byte.
// Limits are written over the APB port at 0x0 (physical) and 0x4 (map); the
// user must write them only while the block is idle (not enforced here).
// Reset clears the parser state, empties both registers and sets both
// limits to 512.
// When result_out stalls, the result register holds, an empty input register
// takes one more byte, and byte_in.ready then drops until the stall ends.
module efuse_tuple_map_parser_unit #(
  parameter int unsigned MAX_PHYSICAL_BYTES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [efmp_pkg::ADDR_W-1:0] paddr,
  input  logic [efmp_pkg::DATA_W-1:0] pwdata,
  output logic [efmp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  efmp_byte_if.sink                   byte_in,
  efmp_result_if.source               result_out
);
  import efmp_pkg::*;

  logic [LIMIT_W-1:0] physical_limit;
  logic [LIMIT_W-1:0] map_limit;

  logic      in_valid;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      step_en;
  logic      has_result;
  out_item_t step_result;

  efmp_cfg_regs u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .physical_limit (physical_limit),
    .map_limit      (map_limit)
  );

  efmp_parse_core #(
    .MAX_PHYSICAL_BYTES (MAX_PHYSICAL_BYTES)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step_en        (step_en),
    .item           (in_item),
    .physical_limit (physical_limit),
    .map_limit      (map_limit),
    .has_result     (has_result),
    .result         (step_result)
  );

  assign step_en       = in_valid && (!out_valid || result_out.ready);
  assign byte_in.ready = !in_valid || step_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      in_item.command    <= byte_in.command;
      in_item.efuse_byte <= byte_in.efuse_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en && has_result) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && has_result) begin
      out_item <= step_result;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.write_valid = out_item.write_valid;
  assign result_out.position    = out_item.position;
  assign result_out.low_byte    = out_item.low_byte;
  assign result_out.high_byte   = out_item.high_byte;
  assign result_out.finished    = out_item.finished;
  assign result_out.end_cause   = out_item.end_cause;

endmodule
